/* rtl/tvna_pkg.sv */
// ----------------------------------------------------------------------------
// tvna_pkg
// Shared widths, codes and types of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tvna_pkg;

	localparam int unsigned DEPTH_DEF = 4096;
	localparam int unsigned ACT_W     = 2;
	localparam int unsigned IDX_W     = 12;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned NRM_W     = 25;
	localparam int unsigned UNIT_W    = 18;
	localparam int unsigned WIDE_W    = 62;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned QUO_W     = 17;
	localparam int unsigned SUM_W     = NRM_W + 1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 26'sd16777215;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -26'sd16777216;
	localparam logic signed [NRM_W-1:0] NRM_ONE = 25'sd65536;
	localparam logic signed [UNIT_W-1:0] UNIT_ONE = 18'sd65536;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_TRI  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;
	typedef logic signed [SUM_W-1:0]  nsum_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic nonzero;
	} uni_stat_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_SCALE,
		U_SQ,
		U_ROOT,
		U_DSET,
		U_DIV,
		U_DONE
	} ustate_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RNI,
		S_RND,
		S_RDA,
		S_RDB,
		S_RDC,
		S_DIFF,
		S_SCL,
		S_MUL,
		S_FACE,
		S_FWAIT,
		S_NRD,
		S_NWAIT,
		S_CWAIT,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

/* rtl/tvna_ram.sv */
// ----------------------------------------------------------------------------
// tvna_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tvna_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/tvna_unitize.sv */
// ----------------------------------------------------------------------------
// tvna_unitize
// Shared vector normaliser: scale, sum of squares, bit-serial root and
// three bit-serial divides giving a Q.16 unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module tvna_unitize (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tvna_pkg::wide_t      vec_x,
	input  tvna_pkg::wide_t      vec_y,
	input  tvna_pkg::wide_t      vec_z,
	output tvna_pkg::unit_t      u_x,
	output tvna_pkg::unit_t      u_y,
	output tvna_pkg::unit_t      u_z,
	output tvna_pkg::uni_stat_t  stat
);
	import tvna_pkg::*;

	ustate_t state_q, state_d;

	logic [WIDE_W-1:0] mag_q [3];
	logic              neg_q [3];
	logic [WIDE_W-1:0] mag_or;
	logic              hi8, hi1, lo8, lo1, is_zero;

	logic [1:0]  sq_cnt_q;
	logic [29:0] sq_op;
	logic [59:0] prod_q;
	logic [63:0] acc_q;

	logic [63:0] rem_q, res_q, bit_q;
	logic [63:0] trial, res_nxt;
	logic        fits;
	logic [31:0] root_q;

	logic [1:0]        comp_q;
	logic [WIDE_W-1:0] comp_mag;
	logic [47:0]       num_q, dvs_q;
	logic [QUO_W-1:0]  quo_q, quo_nxt;
	logic [4:0]        dcnt_q;
	logic              take;
	unit_t             quo_s;

	logic  nz_q;
	unit_t u_q [3];

	assign mag_or  = mag_q[0] | mag_q[1] | mag_q[2];
	assign hi8     = |mag_or[WIDE_W-1:38];
	assign hi1     = |mag_or[WIDE_W-1:30];
	assign lo8     = ~|mag_or[WIDE_W-1:21];
	assign lo1     = ~|mag_or[WIDE_W-1:29];
	assign is_zero = ~|mag_or;

	always_comb begin
		unique case (sq_cnt_q)
			2'd0:    sq_op = mag_q[0][29:0];
			2'd1:    sq_op = mag_q[1][29:0];
			default: sq_op = mag_q[2][29:0];
		endcase
	end

	always_comb begin
		unique case (comp_q)
			2'd0:    comp_mag = mag_q[0];
			2'd1:    comp_mag = mag_q[1];
			default: comp_mag = mag_q[2];
		endcase
	end

	assign trial   = res_q + bit_q;
	assign fits    = rem_q >= trial;
	assign res_nxt = fits ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	assign take    = num_q >= dvs_q;
	assign quo_nxt = {quo_q[QUO_W-2:0], take};
	assign quo_s   = unit_t'({1'b0, quo_nxt});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE:  if (start) state_d = U_SCALE;
			U_SCALE: begin
				if (is_zero) state_d = U_DONE;
				else if (!hi1 && !lo1) state_d = U_SQ;
			end
			U_SQ:    if (sq_cnt_q == 2'd3) state_d = U_ROOT;
			U_ROOT:  if (bit_q[0]) state_d = U_DSET;
			U_DSET:  state_d = U_DIV;
			U_DIV: begin
				if (dcnt_q == 5'd0) state_d = (comp_q == 2'd2) ? U_DONE : U_DSET;
			end
			U_DONE:  state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.busy    = state_q != U_IDLE;
		stat.done    = state_q == U_DONE;
		stat.nonzero = nz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (start) begin
					mag_q[0] <= vec_x[WIDE_W-1] ? WIDE_W'(-vec_x) : WIDE_W'(vec_x);
					mag_q[1] <= vec_y[WIDE_W-1] ? WIDE_W'(-vec_y) : WIDE_W'(vec_y);
					mag_q[2] <= vec_z[WIDE_W-1] ? WIDE_W'(-vec_z) : WIDE_W'(vec_z);
					neg_q[0] <= vec_x[WIDE_W-1];
					neg_q[1] <= vec_y[WIDE_W-1];
					neg_q[2] <= vec_z[WIDE_W-1];
				end
			end
			U_SCALE: begin
				// bring the largest magnitude into [2^29, 2^30)
				for (int i = 0; i < 3; i++) begin
					if (hi8) mag_q[i] <= mag_q[i] >> 8;
					else if (hi1) mag_q[i] <= mag_q[i] >> 1;
					else if (lo8) mag_q[i] <= mag_q[i] << 8;
					else if (lo1) mag_q[i] <= mag_q[i] << 1;
				end
				nz_q     <= !is_zero;
				sq_cnt_q <= 2'd0;
				acc_q    <= '0;
			end
			U_SQ: begin
				if (sq_cnt_q != 2'd3) prod_q <= sq_op * sq_op;
				if (sq_cnt_q == 2'd3) begin
					rem_q <= acc_q + 64'(prod_q);
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end else if (sq_cnt_q != 2'd0) begin
					acc_q <= acc_q + 64'(prod_q);
				end
				sq_cnt_q <= sq_cnt_q + 2'd1;
			end
			U_ROOT: begin
				if (fits) rem_q <= rem_q - trial;
				res_q  <= res_nxt;
				bit_q  <= bit_q >> 2;
				root_q <= res_nxt[31:0];
				comp_q <= 2'd0;
			end
			U_DSET: begin
				// rounded quotient: (mag * 2^16 + root/2) / root
				num_q  <= {2'b00, comp_mag[29:0], 16'h0000} + 48'(root_q >> 1);
				dvs_q  <= {root_q, 16'h0000};
				quo_q  <= '0;
				dcnt_q <= 5'(QUO_W - 1);
			end
			U_DIV: begin
				if (take) num_q <= num_q - dvs_q;
				dvs_q  <= dvs_q >> 1;
				quo_q  <= quo_nxt;
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd0) begin
					u_q[comp_q] <= neg_q[comp_q] ? -quo_s : quo_s;
					comp_q      <= comp_q + 2'd1;
				end
			end
			U_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign u_x = u_q[0];
	assign u_y = u_q[1];
	assign u_z = u_q[2];

endmodule

`default_nettype wire

/* rtl/terrain_vertex_normal_accumulator.sv */
// Vertex normal accumulator. Takes one item at a time and gives one result per item.
// A triangle reads its three positions and forms the cross product with one 31x31
// multiplier, then runs four vector normalisations through one shared unit (face,
// then corners A, B, C), each made of scaling, the sum of squares, the bit-serial
// square root and the bit-serial divides. Skipped or out-of-range triangles finish
// early. The normaliser sets the triangle rate.
// A new item is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
// terrain_vertex_normal_accumulator
// Position and normal stores with a triangle read-modify-write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_vertex_normal_accumulator #(
	parameter int unsigned VERTEX_DEPTH = tvna_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tvna_pkg::ACT_W-1:0]        action,
	input  logic [tvna_pkg::IDX_W-1:0]        index_a,
	input  logic [tvna_pkg::IDX_W-1:0]        index_b,
	input  logic [tvna_pkg::IDX_W-1:0]        index_c,
	input  logic signed [tvna_pkg::POS_W-1:0] pos_x,
	input  logic signed [tvna_pkg::POS_W-1:0] pos_y,
	input  logic signed [tvna_pkg::POS_W-1:0] pos_z,
	input  logic                              is_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tvna_pkg::NRM_W-1:0] normal_x,
	output logic signed [tvna_pkg::NRM_W-1:0] normal_y,
	output logic signed [tvna_pkg::NRM_W-1:0] normal_z,
	output logic                              face_skipped,
	output logic                              saturated,
	output logic                              mesh_done
);
	import tvna_pkg::*;

	localparam int unsigned AW    = $clog2(VERTEX_DEPTH);
	localparam int unsigned PWORD = 3 * POS_W;
	localparam int unsigned NWORD = 3 * NRM_W;

	state_t  state_q, state_d;
	action_t act_in;
	logic    accept;
	logic    a_in, b_in, c_in;

	logic [IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q;
	logic [IDX_W-1:0] corner_idx;
	logic [1:0]       corner_q;

	// position store
	logic             pos_we, pos_re;
	logic [AW-1:0]    pos_raddr;
	logic [PWORD-1:0] pos_rd;

	// normal store
	logic             nrm_we, nrm_re;
	logic [AW-1:0]    nrm_waddr, nrm_raddr;
	logic [NWORD-1:0] nrm_wd, nrm_rd;

	logic signed [POS_W-1:0] pa_q [3];
	logic signed [POS_W-1:0] pb_q [3];
	logic signed [POS_W:0]   da_q [3];
	logic signed [POS_W:0]   dc_q [3];
	logic [POS_W:0]          dmag [6];
	logic                    dneg [6];
	logic [POS_W:0]          dor;
	logic [1:0]              dsh;
	logic [29:0]             dsm [6];
	logic signed [30:0]      dsv [6];
	logic signed [30:0]      sa_q [3];
	logic signed [30:0]      sc_q [3];

	logic [2:0]         mcnt_q;
	logic signed [30:0] op1, op2;
	wide_t              prod_q;
	wide_t              x_q [3];

	unit_t     f_q [3];
	nrm_t      old_q [3];
	nsum_t     csum [3];
	nsum_t     nsum [3];
	nrm_t      nnew [3];
	logic      nclip;

	logic      uni_start;
	wide_t     uvec [3];
	unit_t     u_x, u_y, u_z;
	uni_stat_t uni_stat;

	nrm_t res_n_q [3];
	logic res_skip_q, res_sat_q, res_done_q;

	logic out_valid_q, out_load;

	assign act_in = action_t'(action);
	assign accept = in_valid && in_ready;
	assign a_in   = 32'(index_a) < VERTEX_DEPTH;
	assign b_in   = 32'(index_b) < VERTEX_DEPTH;
	assign c_in   = 32'(index_c) < VERTEX_DEPTH;

	always_comb begin
		unique case (corner_q)
			2'd0:    corner_idx = idx_a_q;
			2'd1:    corner_idx = idx_b_q;
			default: corner_idx = idx_c_q;
		endcase
	end

	// ---------------------------------------------------------------- stores
	assign pos_we = accept && act_in == ACT_LOAD && a_in;
	assign pos_re = state_q == S_RDA || state_q == S_RDB || state_q == S_RDC;

	always_comb begin
		unique case (state_q)
			S_RDA:   pos_raddr = AW'(idx_a_q);
			S_RDB:   pos_raddr = AW'(idx_b_q);
			default: pos_raddr = AW'(idx_c_q);
		endcase
	end

	tvna_ram #(.WIDTH(PWORD), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk     (clk),
		.wr_en   (pos_we),
		.wr_addr (AW'(index_a)),
		.wr_data ({pos_z, pos_y, pos_x}),
		.rd_en   (pos_re),
		.rd_addr (pos_raddr),
		.rd_data (pos_rd)
	);

	// corner sum and clipped accumulation
	always_comb begin
		nclip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			csum[i] = SUM_W'($signed(nrm_rd[NRM_W*i +: NRM_W])) + SUM_W'(f_q[i]);
		end
		nsum[0] = SUM_W'(old_q[0]) + SUM_W'(u_x);
		nsum[1] = SUM_W'(old_q[1]) + SUM_W'(u_y);
		nsum[2] = SUM_W'(old_q[2]) + SUM_W'(u_z);
		for (int i = 0; i < 3; i++) begin
			if (nsum[i] > SUM_MAX) begin
				nnew[i] = NRM_W'(SUM_MAX);
				nclip   = 1'b1;
			end else if (nsum[i] < SUM_MIN) begin
				nnew[i] = NRM_W'(SUM_MIN);
				nclip   = 1'b1;
			end else begin
				nnew[i] = NRM_W'(nsum[i]);
			end
		end
	end

	assign nrm_we    = pos_we ||
		(state_q == S_CWAIT && uni_stat.done && uni_stat.nonzero);
	assign nrm_waddr = (state_q == S_IDLE) ? AW'(index_a) : AW'(corner_idx);
	assign nrm_wd    = (state_q == S_IDLE) ? {nrm_t'(0), NRM_ONE, nrm_t'(0)}
		: {nnew[2], nnew[1], nnew[0]};
	assign nrm_re    = state_q == S_RNI || state_q == S_NRD;
	assign nrm_raddr = (state_q == S_RNI) ? AW'(idx_a_q) : AW'(corner_idx);

	tvna_ram #(.WIDTH(NWORD), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
		.clk     (clk),
		.wr_en   (nrm_we),
		.wr_addr (nrm_waddr),
		.wr_data (nrm_wd),
		.rd_en   (nrm_re),
		.rd_addr (nrm_raddr),
		.rd_data (nrm_rd)
	);

	// ------------------------------------------------------ edge scaling
	always_comb begin
		dor = '0;
		for (int i = 0; i < 3; i++) begin
			dneg[i]     = da_q[i][POS_W];
			dneg[i + 3] = dc_q[i][POS_W];
			dmag[i]     = dneg[i] ? (POS_W + 1)'(-da_q[i]) : (POS_W + 1)'(da_q[i]);
			dmag[i + 3] = dneg[i + 3] ? (POS_W + 1)'(-dc_q[i]) : (POS_W + 1)'(dc_q[i]);
		end
		for (int i = 0; i < 6; i++) begin
			dor = dor | dmag[i];
		end
		// halve until every magnitude is below 2^30
		priority if (dor[32]) dsh = 2'd3;
		else if (dor[31]) dsh = 2'd2;
		else if (dor[30]) dsh = 2'd1;
		else dsh = 2'd0;
		for (int i = 0; i < 6; i++) begin
			dsm[i] = 30'(dmag[i] >> dsh);
			dsv[i] = dneg[i] ? -$signed({1'b0, dsm[i]}) : $signed({1'b0, dsm[i]});
		end
	end

	// cross product operand order: c1a2, c2a1, c2a0, c0a2, c0a1, c1a0
	always_comb begin
		unique case (mcnt_q)
			3'd0:    begin op1 = sc_q[1]; op2 = sa_q[2]; end
			3'd1:    begin op1 = sc_q[2]; op2 = sa_q[1]; end
			3'd2:    begin op1 = sc_q[2]; op2 = sa_q[0]; end
			3'd3:    begin op1 = sc_q[0]; op2 = sa_q[2]; end
			3'd4:    begin op1 = sc_q[0]; op2 = sa_q[1]; end
			default: begin op1 = sc_q[1]; op2 = sa_q[0]; end
		endcase
	end

	// ------------------------------------------------------ normaliser
	assign uni_start = (state_q == S_FACE && !x_q[1][WIDE_W-1]) || state_q == S_NWAIT;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uvec[i] = (state_q == S_FACE) ? x_q[i] : WIDE_W'(csum[i]);
		end
	end

	tvna_unitize u_unitize (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (uni_start),
		.vec_x  (uvec[0]),
		.vec_y  (uvec[1]),
		.vec_z  (uvec[2]),
		.u_x    (u_x),
		.u_y    (u_y),
		.u_z    (u_z),
		.stat   (uni_stat)
	);

	// ------------------------------------------------------ sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (act_in)
						ACT_READ: state_d = a_in ? S_RNI : S_OUT;
						ACT_TRI:  state_d = (a_in && b_in && c_in) ? S_RDA : S_OUT;
						default:  state_d = S_OUT;
					endcase
				end
			end
			S_RNI:   state_d = S_RND;
			S_RND:   state_d = S_OUT;
			S_RDA:   state_d = S_RDB;
			S_RDB:   state_d = S_RDC;
			S_RDC:   state_d = S_DIFF;
			S_DIFF:  state_d = S_SCL;
			S_SCL:   state_d = S_MUL;
			S_MUL:   if (mcnt_q == 3'd6) state_d = S_FACE;
			S_FACE:  state_d = x_q[1][WIDE_W-1] ? S_OUT : S_FWAIT;
			S_FWAIT: begin
				if (uni_stat.done) state_d = uni_stat.nonzero ? S_NRD : S_OUT;
			end
			S_NRD:   state_d = S_NWAIT;
			S_NWAIT: state_d = S_CWAIT;
			S_CWAIT: begin
				if (uni_stat.done) state_d = (corner_q == 2'd2) ? S_OUT : S_NRD;
			end
			S_OUT:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == S_IDLE;
		out_load = state_q == S_OUT && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_a_q    <= index_a;
					idx_b_q    <= index_b;
					idx_c_q    <= index_c;
					res_n_q[0] <= '0;
					res_n_q[1] <= '0;
					res_n_q[2] <= '0;
					res_skip_q <= 1'b0;
					res_sat_q  <= 1'b0;
					res_done_q <= (act_in == ACT_TRI) ? is_last : 1'b0;
				end
			end
			S_RND: begin
				for (int i = 0; i < 3; i++) begin
					res_n_q[i] <= $signed(nrm_rd[NRM_W*i +: NRM_W]);
				end
			end
			S_RDB: begin
				for (int i = 0; i < 3; i++) pa_q[i] <= $signed(pos_rd[POS_W*i +: POS_W]);
			end
			S_RDC: begin
				for (int i = 0; i < 3; i++) pb_q[i] <= $signed(pos_rd[POS_W*i +: POS_W]);
			end
			S_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					da_q[i] <= (POS_W + 1)'(pa_q[i]) - (POS_W + 1)'(pb_q[i]);
					dc_q[i] <= (POS_W + 1)'($signed(pos_rd[POS_W*i +: POS_W]))
						- (POS_W + 1)'(pb_q[i]);
				end
			end
			S_SCL: begin
				for (int i = 0; i < 3; i++) begin
					sa_q[i] <= dsv[i];
					sc_q[i] <= dsv[i + 3];
				end
				mcnt_q <= 3'd0;
			end
			S_MUL: begin
				if (mcnt_q != 3'd6) prod_q <= op1 * op2;
				// fold the product of the previous step
				unique case (mcnt_q)
					3'd1:    x_q[0] <= prod_q;
					3'd2:    x_q[0] <= x_q[0] - prod_q;
					3'd3:    x_q[1] <= prod_q;
					3'd4:    x_q[1] <= x_q[1] - prod_q;
					3'd5:    x_q[2] <= prod_q;
					3'd6:    x_q[2] <= x_q[2] - prod_q;
					default: begin
					end
				endcase
				mcnt_q <= mcnt_q + 3'd1;
			end
			S_FACE: begin
				if (x_q[1][WIDE_W-1]) res_skip_q <= 1'b1;
			end
			S_FWAIT: begin
				if (uni_stat.done) begin
					if (!uni_stat.nonzero) res_skip_q <= 1'b1;
					f_q[0]   <= u_x;
					f_q[1]   <= u_y;
					f_q[2]   <= u_z;
					corner_q <= 2'd0;
				end
			end
			S_NWAIT: begin
				for (int i = 0; i < 3; i++) old_q[i] <= $signed(nrm_rd[NRM_W*i +: NRM_W]);
			end
			S_CWAIT: begin
				if (uni_stat.done) begin
					if (uni_stat.nonzero && nclip) res_sat_q <= 1'b1;
					corner_q <= corner_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			normal_x     <= res_n_q[0];
			normal_y     <= res_n_q[1];
			normal_z     <= res_n_q[2];
			face_skipped <= res_skip_q;
			saturated    <= res_sat_q;
			mesh_done    <= res_done_q;
		end
	end

	assign out_valid = out_valid_q;

	// ------------------------------------------------------ checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		uni_start |-> !uni_stat.busy)
		else $error("normaliser started while busy");

	a_corner_write: assert property (@(posedge clk) disable iff (!arst_n)
		(nrm_we && state_q != S_IDLE) |-> (uni_stat.done && uni_stat.nonzero))
		else $error("corner write without a finished normalisation");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(uni_stat.done && uni_stat.nonzero) |->
		(u_x <= UNIT_ONE && u_x >= -UNIT_ONE && u_y <= UNIT_ONE && u_y >= -UNIT_ONE &&
		 u_z <= UNIT_ONE && u_z >= -UNIT_ONE))
		else $error("unit vector component out of range");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(face_skipped && saturated))
		else $error("skipped triangle reports saturation");

	a_corner_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NRD || state_q == S_CWAIT) |-> corner_q != 2'd3)
		else $error("corner counter overran");

endmodule

`default_nettype wire

/* verif/tvna_checker.sv */
// ----------------------------------------------------------------------------
// tvna_checker
// Watches both channels of the vertex normal accumulator, keeps its own copy
// of the position and normal stores, predicts each result and compares it.
// ----------------------------------------------------------------------------
module tvna_checker
	import tvna_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [ACT_W-1:0]         action,
	input  logic [IDX_W-1:0]         index_a,
	input  logic [IDX_W-1:0]         index_b,
	input  logic [IDX_W-1:0]         index_c,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic                     is_last,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [NRM_W-1:0]  normal_x,
	input  logic signed [NRM_W-1:0]  normal_y,
	input  logic signed [NRM_W-1:0]  normal_z,
	input  logic                     face_skipped,
	input  logic                     saturated,
	input  logic                     mesh_done,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NORM_HI = 16777215;
	localparam int NORM_LO = -16777216;

	typedef struct {
		nrm_t nx;
		nrm_t ny;
		nrm_t nz;
		bit   skipped;
		bit   sat;
		bit   done;
	} vnorm_result_t;

	longint        vpos [DEPTH_DEF][3];
	int            vnrm [DEPTH_DEF][3];
	vnorm_result_t awaited[$];

	assign pending = awaited.size();

	initial begin
		fail_count = 0;
		foreach (vpos[i, j]) begin
			vpos[i][j] = 0;
			vnrm[i][j] = 0;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Unit vector in Q.16; returns 0 for the zero vector.
	function automatic bit to_unit(input longint v[3], output int u[3]);
		longint unsigned m[3];
		longint unsigned mx, ss, r, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0)
			return 0;
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		r = int_sqrt(ss);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 65536 + r / 2) / r;
			u[i] = v[i] < 0 ? -int'(q) : int'(q);
		end
		return 1;
	endfunction

	function automatic void accumulate_corner(int idx, int f[3], inout bit sat);
		longint s[3];
		int     u[3];
		longint t;
		for (int i = 0; i < 3; i++)
			s[i] = longint'(vnrm[idx][i]) + f[i];
		if (!to_unit(s, u))
			return;
		for (int i = 0; i < 3; i++) begin
			t = longint'(vnrm[idx][i]) + u[i];
			if (t > NORM_HI) begin
				t = NORM_HI;
				sat = 1;
			end else if (t < NORM_LO) begin
				t = NORM_LO;
				sat = 1;
			end
			vnrm[idx][i] = int'(t);
		end
	endfunction

	function automatic vnorm_result_t apply_item(action_t act, int ia, int ib, int ic,
			longint px, longint py, longint pz, bit last);
		vnorm_result_t    res;
		longint           da, dc, a[3], c[3], x[3];
		longint unsigned  m[6], mx;
		bit               neg[6];
		int               f[3];
		bit               sat;
		res = '{default: 0};
		case (act)
			ACT_LOAD: begin
				vpos[ia] = '{px, py, pz};
				vnrm[ia] = '{0, 65536, 0};
			end
			ACT_TRI: begin
				res.done = last;
				mx = 0;
				for (int i = 0; i < 3; i++) begin
					da = vpos[ia][i] - vpos[ib][i];
					dc = vpos[ic][i] - vpos[ib][i];
					neg[i] = da < 0;
					m[i] = neg[i] ? -da : da;
					neg[i+3] = dc < 0;
					m[i+3] = neg[i+3] ? -dc : dc;
				end
				for (int i = 0; i < 6; i++)
					if (m[i] > mx)
						mx = m[i];
				while (mx >= (64'd1 << 30)) begin
					for (int i = 0; i < 6; i++)
						m[i] >>= 1;
					mx >>= 1;
				end
				for (int i = 0; i < 3; i++) begin
					a[i] = neg[i] ? -longint'(m[i]) : longint'(m[i]);
					c[i] = neg[i+3] ? -longint'(m[i+3]) : longint'(m[i+3]);
				end
				x[0] = c[1] * a[2] - c[2] * a[1];
				x[1] = c[2] * a[0] - c[0] * a[2];
				x[2] = c[0] * a[1] - c[1] * a[0];
				if (x[1] < 0 || !to_unit(x, f)) begin
					res.skipped = 1;
				end else begin
					sat = 0;
					accumulate_corner(ia, f, sat);
					accumulate_corner(ib, f, sat);
					accumulate_corner(ic, f, sat);
					res.sat = sat;
				end
			end
			ACT_READ: begin
				res.nx = nrm_t'(vnrm[ia][0]);
				res.ny = nrm_t'(vnrm[ia][1]);
				res.nz = nrm_t'(vnrm[ia][2]);
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		vnorm_result_t w;
		if (arst_n) begin
			// Compare first: a result never belongs to the item taken at the same edge.
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					$display("[%0t] result with no item outstanding", $realtime);
					fail_count++;
				end else begin
					w = awaited.pop_front();
					if (normal_x !== w.nx)
						report_mismatch("normal_x", normal_x, w.nx);
					if (normal_y !== w.ny)
						report_mismatch("normal_y", normal_y, w.ny);
					if (normal_z !== w.nz)
						report_mismatch("normal_z", normal_z, w.nz);
					if (face_skipped !== w.skipped)
						report_mismatch("face_skipped", face_skipped, w.skipped);
					if (saturated !== w.sat)
						report_mismatch("saturated", saturated, w.sat);
					if (mesh_done !== w.done)
						report_mismatch("mesh_done", mesh_done, w.done);
				end
			end
			if (in_valid && in_ready)
				awaited.push_back(apply_item(action_t'(action), index_a, index_b, index_c,
					pos_x, pos_y, pos_z, is_last));
		end
	end
endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the vertex normal accumulator: directed loads, triangles and
// reads, then random meshes under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
	import tvna_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 900;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [ACT_W-1:0]        action;
	logic [IDX_W-1:0]        index_a, index_b, index_c;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic                    is_last;
	logic                    out_valid;
	logic                    out_ready;
	nrm_t                    normal_x, normal_y, normal_z;
	logic                    face_skipped, saturated, mesh_done;
	int                      fail_count;
	int                      pending;

	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	bit written[DEPTH_DEF];
	int loaded[$];

	terrain_vertex_normal_accumulator dut (.*);

	tvna_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(action_t act, int a, int b, int c, int x, int y, int z, bit last);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		action  = act;
		index_a = a;
		index_b = b;
		index_c = c;
		pos_x   = x;
		pos_y   = y;
		pos_z   = z;
		is_last = last;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		if (act == ACT_LOAD && !written[a]) begin
			written[a] = 1;
			loaded.push_back(a);
		end
	endtask

	function automatic int rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
			default: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
		endcase
	endfunction

	// Bias towards recent vertices so normals accumulate on shared corners.
	function automatic int pick_vertex();
		if ($urandom_range(1) && loaded.size() > 6)
			return loaded[loaded.size() - 1 - $urandom_range(5)];
		return loaded[$urandom_range(loaded.size() - 1)];
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 25 || loaded.size() < 3)
			send_item(ACT_LOAD, $urandom_range(DEPTH_DEF - 1), $urandom_range(4095),
				$urandom_range(4095), rand_coord(), rand_coord(), rand_coord(), $urandom);
		else if (r < 70)
			send_item(ACT_TRI, pick_vertex(), pick_vertex(), pick_vertex(),
				$urandom, $urandom, $urandom, $urandom_range(9) == 0);
		else if (r < 95)
			send_item(ACT_READ, pick_vertex(), $urandom_range(4095), $urandom_range(4095),
				$urandom, $urandom, $urandom, $urandom);
		else
			send_item(ACT_NONE, $urandom_range(4095), $urandom_range(4095),
				$urandom_range(4095), $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		in_valid = 0;
		action = ACT_NONE;
		index_a = 0;
		index_b = 0;
		index_c = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		is_last = 0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Extremes of the position range and a unit right angle around the origin
		send_item(ACT_LOAD, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_item(ACT_LOAD, 4095, 4095, 4095, 32'h80000000, 32'h80000000, 32'h80000000, 1);
		send_item(ACT_LOAD, 1, 0, 0, 0, 0, 0, 0);
		send_item(ACT_LOAD, 2, 0, 0, 65536, 0, 0, 0);
		send_item(ACT_LOAD, 3, 0, 0, 0, 0, 65536, 0);
		send_item(ACT_LOAD, 5, 0, 0, 0, 0, 0, 0);
		send_item(ACT_LOAD, 6, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0);
		send_item(ACT_TRI, 2, 1, 3, 0, 0, 0, 0);
		send_item(ACT_TRI, 2, 1, 3, 0, 0, 0, 0);
		send_item(ACT_TRI, 3, 1, 2, 0, 0, 0, 0);   // downward face
		send_item(ACT_TRI, 1, 1, 5, 0, 0, 0, 0);   // degenerate face
		send_item(ACT_TRI, 2, 2, 3, 0, 0, 0, 0);   // repeated corner
		send_item(ACT_TRI, 0, 4095, 6, 0, 0, 0, 0);
		send_item(ACT_TRI, 6, 4095, 0, 0, 0, 0, 1);
		send_item(ACT_READ, 2, 0, 0, 0, 0, 0, 0);
		send_item(ACT_READ, 1, 0, 0, 0, 0, 0, 0);
		send_item(ACT_READ, 3, 0, 0, 0, 0, 0, 0);
		send_item(ACT_READ, 0, 4095, 4095, 0, 0, 0, 1);
		send_item(ACT_READ, 4095, 0, 0, 0, 0, 0, 0);
		send_item(ACT_READ, 6, 0, 0, 0, 0, 0, 0);
		send_item(ACT_NONE, 4095, 4095, 4095, -1, -1, -1, 1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n * 4 / RANDOM_ITEMS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			random_item();
		end
		@(negedge clk);
		in_valid = 0;

		wait (pending == 0);
		repeat (500) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* filelist.f */
rtl/tvna_pkg.sv
rtl/tvna_ram.sv
rtl/tvna_unitize.sv
rtl/terrain_vertex_normal_accumulator.sv
verif/tvna_checker.sv
verif/tb_top.sv
